@@ design/tsl_pkg.sv @@
// Package for the transpose search list: action codes, field widths and the
// sequencer state type. No dependencies; tsl_if and transpose_search_list import it.
`default_nettype none

package tsl_pkg;

  // Widths of the fields carried on the channels
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned COUNT_W    = 7;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_FIN
  } tsl_state_t;

endpackage

`default_nettype wire

@@ design/tsl_if.sv @@
// Valid/ready channel interfaces for the transpose search list: the input
// word (action, value) and the result word. Depends on tsl_pkg.
`default_nettype none

interface tsl_in_if;
  import tsl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface tsl_out_if;
  import tsl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic                  swapped;
  logic [POSITION_W-1:0] position;
  logic [COUNT_W-1:0]    count;
  logic                  full_error;

  modport source (output valid, output found, output swapped, output position,
                  output count, output full_error, input ready);
  modport sink   (input valid, input found, input swapped, input position,
                  input count, input full_error, output ready);
endinterface

`default_nettype wire

@@ design/tsl_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module tsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/transpose_search_list.sv @@
// Transpose search list: a list of up to DEPTH signed 32-bit entries held in
// one synchronous RAM (tsl_ram), driven by a read-modify-write sequencer.
//
// Each input word carries an action. Clear empties the list, append stores
// the value at the end (full_error is raised and the value dropped when the
// list already holds DEPTH entries), and search walks the list from the front
// for the first entry equal to the key. A hit that is not at the front trades
// places with the entry before it, so popular keys drift towards the front.
// Every input word produces exactly one result word carrying found, swapped,
// the position of the hit before the swap, the count after the word and
// full_error.
//
// Timing: clear, append and the unused action pass straight from idle to the
// result state. A search reads one entry per cycle through the RAM's single
// read port, and a hit that swaps passes through S_SWAP for the second write.
// The next word can be taken in the cycle after a result is loaded. in_ready
// is high whenever the sequencer is idle, even while the previous result
// still waits in the output register. A stalled receiver holds that result
// and, once the next word has finished, holds the sequencer until the output
// register empties.
//
// Reset clears the entry count and all control state; the RAM is not
// cleared, since no entry at or beyond the count is ever looked at.
// Depends on tsl_pkg, tsl_if and tsl_ram.
`default_nettype none

module transpose_search_list #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tsl_in_if.sink    in_ch,
  tsl_out_if.source out_ch
);
  import tsl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  tsl_state_t state_r, state_nxt;

  // Control state
  logic [CW-1:0] cnt_r, cnt_nxt;         // entries held
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;   // next index to read during a scan
  logic          cmp_vld_r, cmp_vld_nxt; // RAM read data is due this cycle
  logic          out_valid_r, out_valid_nxt;

  // Datapath state
  logic [AW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [VALUE_W-1:0]    prev_r, prev_nxt;  // entry just before the one compared
  logic [VALUE_W-1:0]    key_r, key_nxt;
  logic                  found_r, found_nxt;
  logic                  swapped_r, swapped_nxt;
  logic                  full_r, full_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic                  o_found_r, o_found_nxt;
  logic                  o_swapped_r, o_swapped_nxt;
  logic [POSITION_W-1:0] o_pos_r, o_pos_nxt;
  logic [COUNT_W-1:0]    o_cnt_r, o_cnt_nxt;
  logic                  o_full_r, o_full_nxt;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic slot_free;

  tsl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = o_found_r;
  assign out_ch.swapped    = o_swapped_r;
  assign out_ch.position   = o_pos_r;
  assign out_ch.count      = o_cnt_r;
  assign out_ch.full_error = o_full_r;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ch.ready;

  // The read address follows the scan index; reads outside a scan are ignored.
  assign ram_raddr = rd_idx_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    prev_nxt      = prev_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    swapped_nxt   = swapped_r;
    full_nxt      = full_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_found_nxt   = o_found_r;
    o_swapped_nxt = o_swapped_r;
    o_pos_nxt     = o_pos_r;
    o_cnt_nxt     = o_cnt_r;
    o_full_nxt    = o_full_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = in_ch.value;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          key_nxt     = in_ch.value;
          found_nxt   = 1'b0;
          swapped_nxt = 1'b0;
          full_nxt    = 1'b0;
          pos_nxt     = '0;
          state_nxt   = S_FIN;
          case (in_ch.action)
            ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            ACT_APPEND: begin
              if (cnt_r < DEPTH_C) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            ACT_SEARCH: begin
              rd_idx_nxt  = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            default: begin
              // Unused code: state untouched, result carries the count only.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp_vld_r && (ram_rdata == key_r)) begin
          // First hit: stop issuing reads. A hit behind the front starts the
          // swap by moving the predecessor up into the hit's slot.
          found_nxt   = 1'b1;
          pos_nxt     = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          if (cmp_idx_r != '0) begin
            ram_we      = 1'b1;
            ram_waddr   = cmp_idx_r;
            ram_wdata   = prev_r;
            swapped_nxt = 1'b1;
            state_nxt   = S_SWAP;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          if (cmp_vld_r) begin
            prev_nxt = ram_rdata;
          end
          if (rd_idx_r < cnt_r) begin
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = rd_idx_r[AW-1:0];
            rd_idx_nxt  = rd_idx_r + CW'(1);
          end else begin
            cmp_vld_nxt = 1'b0;
            if (!cmp_vld_r) begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_SWAP: begin
        // Second half of the swap: the key takes the predecessor's slot.
        ram_we    = 1'b1;
        ram_waddr = pos_r - AW'(1);
        ram_wdata = key_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = found_r;
          o_swapped_nxt = swapped_r;
          o_pos_nxt     = POSITION_W'(pos_r);
          o_cnt_nxt     = COUNT_W'(cnt_r);
          o_full_nxt    = full_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    prev_r      <= prev_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    swapped_r   <= swapped_nxt;
    full_r      <= full_nxt;
    pos_r       <= pos_nxt;
    o_found_r   <= o_found_nxt;
    o_swapped_r <= o_swapped_nxt;
    o_pos_r     <= o_pos_nxt;
    o_cnt_r     <= o_cnt_nxt;
    o_full_r    <= o_full_nxt;
  end

endmodule

`default_nettype wire
